/* hw/rtl/blae_pkg.sv */
// blae_pkg: payload and control types shared by the bucket list append engine
// no dependencies; imported by the bin table, the top level and the testbench

package blae_pkg;

  // one insert request
  typedef struct packed {
    logic [7:0]         bin_index;
    logic signed [31:0] item_value;
  } blae_in_t;

  // one insert result
  typedef struct packed {
    logic        accepted;
    logic [9:0]  slot_index;
    logic [10:0] bin_count;
    logic [10:0] max_bin_count;
    logic [10:0] total_count;
  } blae_out_t;

  // bin table controls from the insert stage
  typedef struct packed {
    logic rd;     // look up the bin of the incoming item
    logic wr;     // commit size and tail of the current bin
    logic first;  // bin was empty, so the head is written as well
  } blae_bin_ctl_t;

endpackage

/* hw/rtl/blae_ram.sv */
// blae_ram: generic single write port ram with registered read
// no dependencies; used for every store of the engine

module blae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/blae_link_store.sv */
// blae_link_store: next-link store with its clearing sweep after reset
// depends on blae_ram

module blae_link_store #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]    wr_addr_i,
  input  logic [$clog2(2*MAX_ENTRIES)-1:0]  wr_data_i,
  output logic                              busy_o
);

  localparam int SlotW = $clog2(MAX_ENTRIES);
  localparam int LinkW = $clog2(2 * MAX_ENTRIES);
  localparam logic [LinkW-1:0] LinkNone = LinkW'(2 * MAX_ENTRIES - 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_ENTRIES - 1);

  logic             clr_q;
  logic [SlotW-1:0] clr_addr_q;
  logic             ram_we;
  logic [SlotW-1:0] ram_addr;
  logic [LinkW-1:0] ram_wdata;

  // sweep every entry to the none marker, one a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + SlotW'(1);
      if (clr_addr_q == LastSlot) begin
        clr_q <= 1'b0;
      end
    end
  end

  // sweep owns the port until it is done
  assign ram_we    = clr_q || wr_en_i;
  assign ram_addr  = clr_q ? clr_addr_q : wr_addr_i;
  assign ram_wdata = clr_q ? LinkNone : wr_data_i;
  assign busy_o    = clr_q;

  blae_ram #(
    .WIDTH(LinkW),
    .DEPTH(MAX_ENTRIES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(ram_wdata),
    .re_i   (1'b0),
    .raddr_i('0),
    .rdata_o()
  );

endmodule

/* hw/rtl/blae_bin_table.sv */
// blae_bin_table: per-bin head, tail and size stores plus size valid bits
// depends on blae_pkg and blae_ram

module blae_bin_table
  import blae_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int NUM_BINS    = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  blae_bin_ctl_t                       ctl_i,
  input  logic [$clog2(NUM_BINS)-1:0]         rd_addr_i,
  input  logic [$clog2(NUM_BINS)-1:0]         cur_addr_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]    wr_size_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]      wr_slot_i,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]    size_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]      tail_o,
  output logic                                size_vld_o
);

  localparam int CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int SlotW = $clog2(MAX_ENTRIES);

  logic [NUM_BINS-1:0] vld_q;

  // a bin never written reads as size zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.wr) begin
      vld_q[cur_addr_i] <= 1'b1;
    end
  end

  assign size_vld_o = vld_q[cur_addr_i];

  blae_ram #(
    .WIDTH(CntW),
    .DEPTH(NUM_BINS)
  ) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.wr),
    .waddr_i(cur_addr_i),
    .wdata_i(wr_size_i),
    .re_i   (ctl_i.rd),
    .raddr_i(rd_addr_i),
    .rdata_o(size_o)
  );

  blae_ram #(
    .WIDTH(SlotW),
    .DEPTH(NUM_BINS)
  ) u_tail_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.wr),
    .waddr_i(cur_addr_i),
    .wdata_i(wr_slot_i),
    .re_i   (ctl_i.rd),
    .raddr_i(rd_addr_i),
    .rdata_o(tail_o)
  );

  // head only changes on the first entry of a bin
  blae_ram #(
    .WIDTH(SlotW),
    .DEPTH(NUM_BINS)
  ) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (ctl_i.wr && ctl_i.first),
    .waddr_i(cur_addr_i),
    .wdata_i(wr_slot_i),
    .re_i   (1'b0),
    .raddr_i('0),
    .rdata_o()
  );

endmodule

/* hw/rtl/bucket_list_append_engine_top.sv */
// bucket_list_append_engine_top: insert stage, counters and result register
// depends on blae_pkg, blae_ram, blae_bin_table and blae_link_store

// Appends each (bin, value) transfer to that bin's linked list in a shared
// value store, handing out slots in order 0, 1, 2, ... and returning the slot,
// the bin's new count, the running maximum bin count and the total count.
// Inserts beyond MAX_ENTRIES, or to a bin at or above NUM_BINS, are rejected
// with accepted low and no state change. One insert is taken every cycle
// unless the result side stalls or the sweep runs; each transfer passes
// through the registered read of the bin table and then the result
// register. Back-to-back inserts to the same bin are forwarded, so no
// bubble is needed. After reset the next-link store is swept to the none
// marker, which holds off inserts until the sweep is done.

module bucket_list_append_engine_top
  import blae_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int NUM_BINS    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  blae_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output blae_out_t out_data_o
);

  localparam int SlotW = $clog2(MAX_ENTRIES);
  localparam int CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int LinkW = $clog2(2 * MAX_ENTRIES);
  localparam int BinAw = $clog2(NUM_BINS);

  // insert stage
  logic                s1_valid_q;
  blae_in_t            s1_data_q;
  logic                fwd_hit_q;
  logic                fwd_hit_d;
  logic [CntW-1:0]     fwd_size_q;
  logic [SlotW-1:0]    fwd_tail_q;
  logic [CntW-1:0]     fill_q;
  logic [CntW-1:0]     fill_d;
  logic [CntW-1:0]     largest_q;
  logic [CntW-1:0]     largest_d;
  logic                out_valid_q;
  blae_out_t           out_data_q;
  blae_out_t           out_data_d;

  logic                clr_busy;
  logic                in_fire;
  logic                s1_fire;
  logic                bin_ok;
  logic                full;
  logic                store;
  logic                commit;
  logic                link_we;
  logic [CntW-1:0]     ram_size;
  logic [SlotW-1:0]    ram_tail;
  logic                size_vld;
  logic [CntW-1:0]     cur_size;
  logic [CntW-1:0]     cnt;
  logic [CntW-1:0]     new_cnt;
  logic [SlotW-1:0]    cur_tail;
  logic [SlotW-1:0]    slot;
  logic [BinAw-1:0]    s1_addr;
  blae_bin_ctl_t       bin_ctl;

  // handshakes
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy && (!s1_valid_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  // bin lookup with forwarding from a commit in the same cycle as the read
  assign s1_addr  = BinAw'(s1_data_q.bin_index);
  assign bin_ok   = 32'(s1_data_q.bin_index) < NUM_BINS;
  assign cur_size = fwd_hit_q ? fwd_size_q : (size_vld ? ram_size : '0);
  assign cur_tail = fwd_hit_q ? fwd_tail_q : ram_tail;
  assign cnt      = bin_ok ? cur_size : '0;

  // insert decision and new counts
  assign full    = fill_q >= CntW'(MAX_ENTRIES);
  assign store   = bin_ok && !full;
  assign commit  = s1_fire && store;
  assign slot    = SlotW'(fill_q);
  assign new_cnt = cnt + CntW'(1);

  always_comb begin
    largest_d = largest_q;
    fill_d    = fill_q;
    if (store) begin
      fill_d = fill_q + CntW'(1);
      if (new_cnt > largest_q) begin
        largest_d = new_cnt;
      end
    end
  end

  always_comb begin
    out_data_d.accepted      = store;
    out_data_d.slot_index    = store ? 10'(slot) : '0;
    out_data_d.bin_count     = store ? 11'(new_cnt) : 11'(cnt);
    out_data_d.max_bin_count = 11'(largest_d);
    out_data_d.total_count   = 11'(fill_d);
  end

  assign fwd_hit_d = commit && (in_data_i.bin_index == s1_data_q.bin_index);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fill_q      <= '0;
      largest_q   <= '0;
      fwd_hit_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= fwd_hit_d;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        fill_q      <= fill_d;
        largest_q   <= largest_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q  <= in_data_i;
      fwd_size_q <= new_cnt;
      fwd_tail_q <= slot;
    end
    if (s1_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // bin table
  assign bin_ctl.rd    = in_fire;
  assign bin_ctl.wr    = commit;
  assign bin_ctl.first = (cnt == '0);

  blae_bin_table #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .NUM_BINS   (NUM_BINS)
  ) u_bin_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (bin_ctl),
    .rd_addr_i (BinAw'(in_data_i.bin_index)),
    .cur_addr_i(s1_addr),
    .wr_size_i (new_cnt),
    .wr_slot_i (slot),
    .size_o    (ram_size),
    .tail_o    (ram_tail),
    .size_vld_o(size_vld)
  );

  // link the old tail to the new slot when the bin already had entries
  assign link_we = commit && (cnt != '0) && (CntW'(cur_tail) < CntW'(MAX_ENTRIES));

  blae_link_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_link_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (link_we),
    .wr_addr_i(cur_tail),
    .wr_data_i(LinkW'(slot)),
    .busy_o   (clr_busy)
  );

  // value store
  blae_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(MAX_ENTRIES)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (commit),
    .waddr_i(slot),
    .wdata_i(VALUE_WIDTH'(s1_data_q.item_value)),
    .re_i   (1'b0),
    .raddr_i('0),
    .rdata_o()
  );

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(MAX_ENTRIES))
    else $error("fill count beyond store size");

  a_largest_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    largest_q <= fill_q)
    else $error("largest bin exceeds total count");

  a_commit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> fill_q == $past(fill_q) + CntW'(1))
    else $error("fill count not advanced by a stored insert");

  a_result_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q.bin_count <= out_data_q.max_bin_count) &&
                    (out_data_q.max_bin_count <= out_data_q.total_count))
    else $error("result counts inconsistent");
`endif

endmodule

/* bench/testbench.sv */
// testbench: self-checking regression for bucket_list_append_engine_top
// depends on blae_pkg and the engine rtl; keeps its own bin counters to predict each result

`timescale 1ns / 1ps

module testbench;
  import blae_pkg::*;

  localparam int NUM_SLOTS    = 1024;
  localparam int NUM_BUCKETS  = 256;
  localparam int DRAIN_CYCLES = 8;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  blae_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  blae_out_t out_data_o;

  bucket_list_append_engine_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // predicted bucket state
  logic [10:0] bucket_fill [NUM_BUCKETS];
  logic [10:0] entries_held;
  logic [10:0] deepest_bucket;

  blae_out_t pending_results [$];
  int        fail_count;
  int        stored_seen;
  int        rejected_seen;
  int        burst_left;
  bit        hold_burst;

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // work out the result of one insert and advance the predicted state
  function automatic blae_out_t predict_insert(input blae_in_t req);
    blae_out_t   res;
    logic [10:0] cnt;
    cnt = bucket_fill[req.bin_index];
    res.accepted      = 1'b0;
    res.slot_index    = '0;
    res.bin_count     = cnt;
    res.max_bin_count = deepest_bucket;
    res.total_count   = entries_held;
    if (entries_held < NUM_SLOTS) begin
      res.accepted   = 1'b1;
      res.slot_index = entries_held[9:0];
      cnt            = cnt + 11'd1;
      bucket_fill[req.bin_index] = cnt;
      entries_held   = entries_held + 11'd1;
      if (cnt > deepest_bucket) deepest_bucket = cnt;
      res.bin_count     = cnt;
      res.max_bin_count = deepest_bucket;
      res.total_count   = entries_held;
    end
    return res;
  endfunction

  task automatic compare_field(input string fname, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", fname, exp_v, got_v);
      fail_count++;
    end
  endtask

  // record accepted inserts and check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    blae_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) pending_results.push_back(predict_insert(in_data_i));
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no insert outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("accepted", int'(want.accepted), int'(out_data_o.accepted));
          compare_field("slot_index", int'(want.slot_index), int'(out_data_o.slot_index));
          compare_field("bin_count", int'(want.bin_count), int'(out_data_o.bin_count));
          compare_field("max_bin_count", int'(want.max_bin_count),
                        int'(out_data_o.max_bin_count));
          compare_field("total_count", int'(want.total_count),
                        int'(out_data_o.total_count));
          if (out_data_o.accepted) stored_seen++;
          else rejected_seen++;
        end
      end
    end
  end

  // receiver back-pressure, switching at random among four patterns
  int rx_mode;
  int rx_cycle;
  int rx_stall;
  always @(negedge clk_i) begin
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    rx_cycle++;
    case (rx_mode)
      0: out_ready_i = 1'b1;
      1: out_ready_i = ($urandom_range(0, 9) < 7);
      2: out_ready_i = (rx_cycle % 4 == 0);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          out_ready_i = 1'b0;
        end else begin
          out_ready_i = 1'b1;
          if ($urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 12);
        end
      end
    endcase
  end

  // one insert transfer, with random bursts and gaps on the sending side
  task automatic send_insert(input logic [7:0] bin, input logic [31:0] value);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0 && !hold_burst) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i           = 1'b1;
    in_data_i.bin_index  = bin;
    in_data_i.item_value = value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // a few hot buckets make deep lists and push the running maximum
  function automatic logic [7:0] pick_bucket();
    logic [7:0] hot [4] = '{8'd7, 8'd128, 8'd200, 8'd255};
    if ($urandom_range(0, 9) < 4) return hot[2'($urandom_range(0, 3))];
    return 8'($urandom_range(0, NUM_BUCKETS - 1));
  endfunction

  // extremes of bucket and value, first entry of each bucket
  task automatic test_field_extremes();
    send_insert(8'd0,   32'h8000_0000);
    send_insert(8'd255, 32'h7fff_ffff);
    send_insert(8'd0,   32'h0000_0000);
    send_insert(8'd255, 32'hffff_ffff);
    send_insert(8'h55,  32'h5555_5555);
    send_insert(8'haa,  32'haaaa_aaaa);
    send_insert(8'h01,  32'h0000_0001);
    send_insert(8'h80,  32'hfffe_0000);
  endtask

  // back-to-back appends to one bucket and interleaved buckets, no gaps
  task automatic test_chain_appends();
    hold_burst = 1'b1;
    repeat (6) send_insert(8'd7, pick_value());
    repeat (3) begin
      send_insert(8'd8, pick_value());
      send_insert(8'd7, pick_value());
    end
    hold_burst = 1'b0;
  endtask

  // random inserts until the store has filled
  task automatic test_random_fill();
    repeat (1100) send_insert(pick_bucket(), pick_value());
  endtask

  // store full: every insert rejected, counts unchanged
  task automatic test_store_full();
    send_insert(8'd7,   32'h1234_5678);
    send_insert(8'd0,   32'h8000_0000);
    send_insert(8'd255, 32'h7fff_ffff);
    repeat (770) send_insert(8'($urandom_range(0, NUM_BUCKETS - 1)), $urandom());
  endtask

  initial begin
    for (int b = 0; b < NUM_BUCKETS; b++) bucket_fill[b] = '0;
    entries_held   = '0;
    deepest_bucket = '0;
    fail_count     = 0;
    stored_seen    = 0;
    rejected_seen  = 0;
    burst_left     = 0;
    hold_burst     = 1'b0;
    rx_mode        = 0;
    rx_cycle       = 0;
    rx_stall       = 0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    rst_ni         = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_field_extremes();
    test_chain_appends();
    drain_results();
    test_random_fill();
    drain_results();
    test_store_full();
    drain_results();

    $display("covered %0d stored and %0d rejected inserts, deepest bucket %0d",
             stored_seen, rejected_seen, deepest_bucket);
    if (fail_count == 0) begin
      $display("bucket_list_append_engine_top regression: pass");
    end else begin
      $display("bucket_list_append_engine_top regression: fail");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("bucket_list_append_engine_top regression: fail");
    $finish;
  end

endmodule
